// ----- sv/gblur_pkg.sv -----
// ----------------------------------------------------------------------------
// gblur_pkg - shared types and constants of the separable Gaussian blur
// Widths, register codes, sequencer states and the cell control word.
// ----------------------------------------------------------------------------
package gblur_pkg;

	localparam int PIX_W  = 8;
	localparam int NCH    = 3;
	localparam int DATA_W = NCH * PIX_W;
	localparam int TAP_W  = 16;
	localparam int PROD_W = TAP_W + PIX_W;
	localparam int ACC_W  = 27;
	localparam int FRAC_W = 15;
	localparam int SIZE_FIELD_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_HALF   = 3;

	localparam int RST_FRAME_SIZE = 1024;
	localparam logic [CFG_DATA_W-1:0] RST_TAPS = 64'd32768;
	localparam logic [1:0] RST_CHANNELS = 2'd1;
	localparam logic [1:0] COLOR_CHANNELS = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_KERNEL_HALF,
		REG_X_TAPS,
		REG_Y_TAPS,
		REG_CHANNEL_COUNT
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic                  start;
		logic                  rd_valid;
		logic                  center;
		logic [TAP_W-1:0]      x_tap;
		logic                  prod_valid;
		logic [1:0]            kernel_half;
		logic [CFG_DATA_W-1:0] y_taps;
	} cell_ctl_t;

	function automatic logic [PIX_W-1:0] sat8(input logic [ACC_W-1:0] acc);
		logic [ACC_W-FRAC_W-1:0] v;
		begin
			v = acc[ACC_W-1:FRAC_W];
			return (v > (ACC_W-FRAC_W)'(255)) ? 8'hFF : v[PIX_W-1:0];
		end
	endfunction

endpackage

// ----- sv/gblur_ram.sv -----
// ----------------------------------------------------------------------------
// gblur_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gblur_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/gblur_cell.sv -----
// ----------------------------------------------------------------------------
// gblur_cell - one vertical tap position of the blur
// Horizontal MAC over its clamped ring row, saturation, vertical tap product,
// and one step of the vertical sum chain handed on to the next cell.
// ----------------------------------------------------------------------------
module gblur_cell #(
	parameter int RING_ROWS = 8,
	parameter int ROW_W     = 10,
	parameter int OFFSET    = 0
) (
	input  logic                                          clk,
	input  gblur_pkg::cell_ctl_t                          ctl,
	input  logic [ROW_W-1:0]                              em_row,
	input  logic [ROW_W-1:0]                              row_last,
	input  logic [RING_ROWS-1:0][gblur_pkg::DATA_W-1:0]   pix,
	input  logic [gblur_pkg::NCH-1:0][gblur_pkg::ACC_W-1:0] psum_i,
	output logic [gblur_pkg::NCH-1:0][gblur_pkg::ACC_W-1:0] psum_o,
	output logic [gblur_pkg::DATA_W-1:0]                  raw
);

	localparam int RB   = $clog2(RING_ROWS);
	localparam int DIST = (OFFSET < 0) ? -OFFSET : OFFSET;
	localparam logic signed [ROW_W+1:0] OFFS_S = (ROW_W+2)'(OFFSET);

	logic signed [ROW_W+1:0]                          row_s;
	logic [ROW_W-1:0]                                 row_c;
	logic [gblur_pkg::DATA_W-1:0]                     pix_sel;
	logic                                             active;
	logic [gblur_pkg::TAP_W-1:0]                      y_tap;
	logic [gblur_pkg::NCH-1:0][gblur_pkg::PROD_W-1:0] prod_s2;
	logic [gblur_pkg::NCH-1:0][gblur_pkg::ACC_W-1:0]  acc_q;
	logic [gblur_pkg::NCH-1:0][gblur_pkg::PIX_W-1:0]  hs_q;
	logic [gblur_pkg::NCH-1:0][gblur_pkg::PROD_W-1:0] vprod_q;
	logic [gblur_pkg::NCH-1:0][gblur_pkg::ACC_W-1:0]  psum_q;
	logic [gblur_pkg::DATA_W-1:0]                     raw_q;

	always_comb begin
		row_s = $signed({2'b00, em_row}) + OFFS_S;
		if (row_s < 0) begin
			row_c = '0;
		end else if (row_s > $signed({2'b00, row_last})) begin
			row_c = row_last;
		end else begin
			row_c = row_s[ROW_W-1:0];
		end
		pix_sel = pix[row_c[RB-1:0]];
		active  = 32'(ctl.kernel_half) >= DIST;
		y_tap   = ctl.y_taps[gblur_pkg::TAP_W*DIST +: gblur_pkg::TAP_W];
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < gblur_pkg::NCH; ch++) begin
			prod_s2[ch] <= ctl.x_tap * pix_sel[gblur_pkg::PIX_W*ch +: gblur_pkg::PIX_W];
			if (ctl.start) begin
				acc_q[ch] <= '0;
			end else if (ctl.prod_valid) begin
				acc_q[ch] <= acc_q[ch] + gblur_pkg::ACC_W'(prod_s2[ch]);
			end
			hs_q[ch]    <= gblur_pkg::sat8(acc_q[ch]);
			vprod_q[ch] <= active ? y_tap * hs_q[ch] : '0;
			psum_q[ch]  <= psum_i[ch] + gblur_pkg::ACC_W'(vprod_q[ch]);
		end
		if (ctl.rd_valid && ctl.center) begin
			raw_q <= pix_sel;
		end
	end

	assign psum_o = psum_q;
	assign raw    = raw_q;

endmodule

// ----- sv/separable_gaussian_blur_unit.sv -----
// ----------------------------------------------------------------------------
// separable_gaussian_blur_unit - separable Gaussian blur on a pixel stream
// Pixels arrive in raster order and are stored in a ring of line RAMs, one
// RAM per ring row, so no clearing pass is needed after reset. Each output
// lags its input by kernel_half*frame_width + min(kernel_half, frame_width-1)
// pixels; drain words flush the tail of a frame. A word that yields no output
// is taken without leaving the idle state. A word that yields an output holds
// the input off until its result is loaded into the output register: the tap
// sequencer reads one column of every ring row per cycle, each cell of the
// chain accumulates its row horizontally, and the vertical sum then ripples
// through the 2*MAX_HALF+1 cells. A finished word waits in the output
// register while the next input word is taken.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_unit #(
	parameter int MAX_WIDTH  = gblur_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gblur_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_HALF   = gblur_pkg::DEF_MAX_HALF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [gblur_pkg::DATA_W-1:0]       s_axis_tdata,  // in_ch0, in_ch1, in_ch2
	input  logic                               s_axis_tuser,  // cmd
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [gblur_pkg::DATA_W-1:0]       m_axis_tdata,  // out_ch0, out_ch1, out_ch2
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gblur_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gblur_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int NCELL   = 2 * MAX_HALF + 1;
	localparam int RING    = 1 << $clog2(2 * MAX_HALF + 2);
	localparam int RB      = $clog2(RING);
	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int FWW     = $clog2(MAX_WIDTH + 1);
	localparam int RW      = $clog2(MAX_HEIGHT);
	localparam int FHW     = $clog2(MAX_HEIGHT + 1);
	localparam int LAG_MAX = MAX_HALF * MAX_WIDTH + MAX_HALF;
	localparam int LW      = $clog2(LAG_MAX + 1);
	localparam int FIN_MAX = 2 * MAX_HALF + 5 + NCELL;
	localparam int CNTW    = $clog2(FIN_MAX + 1);
	localparam int SW      = ((CW > CNTW) ? CW : CNTW) + 2;
	localparam int FW_RST  = (MAX_WIDTH < gblur_pkg::RST_FRAME_SIZE) ?
		MAX_WIDTH : gblur_pkg::RST_FRAME_SIZE;
	localparam int FH_RST  = (MAX_HEIGHT < gblur_pkg::RST_FRAME_SIZE) ?
		MAX_HEIGHT : gblur_pkg::RST_FRAME_SIZE;

	// configuration
	logic [FWW-1:0]                   frame_width_q;
	logic [FHW-1:0]                   frame_height_q;
	logic [1:0]                       kernel_half_q;
	logic [gblur_pkg::CFG_DATA_W-1:0] x_taps_q;
	logic [gblur_pkg::CFG_DATA_W-1:0] y_taps_q;
	logic [1:0]                       channel_count_q;
	logic [gblur_pkg::SIZE_FIELD_W-1:0] cfg_size;
	logic [1:0]                       cfg_half;
	logic                             cfg_wr;
	logic                             cfg_geom;

	// frame positions
	logic [CW-1:0] in_col_q, in_col_n, out_col_q, out_col_n, ob_col;
	logic [RW-1:0] in_row_q, in_row_n, out_row_q, out_row_n, ob_row;
	logic          frame_done_q, fd_n;
	logic [LW-1:0] pix_cnt_q, pix_cnt_n, lag;
	logic [FWW-1:0] side;
	logic          in_acc, is_pix, emit, fe;

	// sequencer
	gblur_pkg::state_t state_q, state_n;
	logic [CNTW-1:0] cnt_q, fin;
	logic [CW-1:0]   em_col_q, rd_col, col_last;
	logic [RW-1:0]   em_row_q, row_last;
	logic            fe_q;
	logic            start, rd_en, load_out, out_free;
	logic signed [SW-1:0] col_s;
	logic [1:0]      tap_idx;
	logic            center;
	logic            rd_v_s1, rd_v_s2, center_s1;
	logic [gblur_pkg::TAP_W-1:0] xtap_s1;

	// datapath
	logic [RING-1:0][gblur_pkg::DATA_W-1:0]                ring_pix;
	logic [NCELL:0][gblur_pkg::NCH-1:0][gblur_pkg::ACC_W-1:0] chain;
	logic [NCELL-1:0][gblur_pkg::DATA_W-1:0]               raw;
	gblur_pkg::cell_ctl_t                                  ctl;
	logic [gblur_pkg::NCH-1:0][gblur_pkg::PIX_W-1:0]       res;
	logic                                                  out_valid_q, out_last_q;
	logic [gblur_pkg::DATA_W-1:0]                          out_data_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_size  = cfg_data[gblur_pkg::SIZE_FIELD_W-1:0];
	assign cfg_half  = cfg_data[1:0];
	assign cfg_geom  = cfg_wr && ((cfg_index == gblur_pkg::REG_FRAME_WIDTH) ||
		(cfg_index == gblur_pkg::REG_FRAME_HEIGHT) ||
		(cfg_index == gblur_pkg::REG_KERNEL_HALF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FWW'(FW_RST);
			frame_height_q  <= FHW'(FH_RST);
			kernel_half_q   <= '0;
			x_taps_q        <= gblur_pkg::RST_TAPS;
			y_taps_q        <= gblur_pkg::RST_TAPS;
			channel_count_q <= gblur_pkg::RST_CHANNELS;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				gblur_pkg::REG_FRAME_WIDTH: begin
					if (cfg_size == '0) frame_width_q <= FWW'(1);
					else if (32'(cfg_size) > MAX_WIDTH) frame_width_q <= FWW'(MAX_WIDTH);
					else frame_width_q <= FWW'(cfg_size);
				end
				gblur_pkg::REG_FRAME_HEIGHT: begin
					if (cfg_size == '0) frame_height_q <= FHW'(1);
					else if (32'(cfg_size) > MAX_HEIGHT) frame_height_q <= FHW'(MAX_HEIGHT);
					else frame_height_q <= FHW'(cfg_size);
				end
				gblur_pkg::REG_KERNEL_HALF: begin
					if (32'(cfg_half) > MAX_HALF) kernel_half_q <= 2'(MAX_HALF);
					else kernel_half_q <= cfg_half;
				end
				gblur_pkg::REG_X_TAPS:        x_taps_q <= cfg_data;
				gblur_pkg::REG_Y_TAPS:        y_taps_q <= cfg_data;
				gblur_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_half;
				default: ;
			endcase
		end
	end

	// position bookkeeping for one accepted word
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign is_pix = !s_axis_tuser;

	always_comb begin
		side = (FWW'(kernel_half_q) < frame_width_q - FWW'(1)) ?
			FWW'(kernel_half_q) : frame_width_q - FWW'(1);
		lag  = LW'(kernel_half_q) * LW'(frame_width_q) + LW'(side);
	end

	always_comb begin
		in_col_n  = in_col_q;
		in_row_n  = in_row_q;
		pix_cnt_n = pix_cnt_q;
		fd_n      = frame_done_q;
		ob_row    = out_row_q;
		ob_col    = out_col_q;
		emit      = 1'b0;
		if (is_pix) begin
			if (frame_done_q) begin
				ob_row = '0;
				ob_col = '0;
			end
			fd_n = 1'b0;
			emit = pix_cnt_q >= lag;
			if (FWW'(in_col_q) + FWW'(1) >= frame_width_q) begin
				in_col_n = '0;
				if (FHW'(in_row_q) + FHW'(1) >= frame_height_q) begin
					in_row_n = '0;
					fd_n     = 1'b1;
				end else begin
					in_row_n = in_row_q + RW'(1);
				end
			end else begin
				in_col_n = in_col_q + CW'(1);
			end
			if (fd_n) begin
				pix_cnt_n = '0;
			end else if (!emit) begin
				pix_cnt_n = pix_cnt_q + LW'(1);
			end
		end else begin
			emit = frame_done_q;
		end
		fe = (FHW'(ob_row) == frame_height_q - FHW'(1)) &&
			(FWW'(ob_col) == frame_width_q - FWW'(1));
		out_row_n = ob_row;
		out_col_n = ob_col;
		if (emit) begin
			if (FWW'(ob_col) + FWW'(1) >= frame_width_q) begin
				out_col_n = '0;
				if (FHW'(ob_row) + FHW'(1) >= frame_height_q) begin
					out_row_n = '0;
					fd_n      = 1'b0;
				end else begin
					out_row_n = ob_row + RW'(1);
				end
			end else begin
				out_col_n = ob_col + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			frame_done_q <= 1'b0;
			pix_cnt_q    <= '0;
		end else if (cfg_geom) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			frame_done_q <= 1'b0;
			pix_cnt_q    <= '0;
		end else if (in_acc) begin
			in_col_q     <= in_col_n;
			in_row_q     <= in_row_n;
			out_col_q    <= out_col_n;
			out_row_q    <= out_row_n;
			frame_done_q <= fd_n;
			pix_cnt_q    <= pix_cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			em_row_q <= ob_row;
			em_col_q <= ob_col;
			fe_q     <= fe;
		end
	end

	// tap sequencer
	assign start    = in_acc && emit;
	assign fin      = CNTW'({kernel_half_q, 1'b0}) + CNTW'(NCELL + 5);
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			gblur_pkg::ST_IDLE: if (start) state_n = gblur_pkg::ST_RUN;
			gblur_pkg::ST_RUN:  if (cnt_q == fin && out_free) state_n = gblur_pkg::ST_IDLE;
			default:            state_n = gblur_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			gblur_pkg::ST_IDLE: s_axis_tready = 1'b1;
			gblur_pkg::ST_RUN: begin
				rd_en    = cnt_q <= CNTW'({kernel_half_q, 1'b0});
				load_out = (cnt_q == fin) && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gblur_pkg::ST_IDLE;
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
			rd_v_s2 <= 1'b0;
		end else begin
			state_q <= state_n;
			if (start) begin
				cnt_q <= '0;
			end else if (state_q == gblur_pkg::ST_RUN && cnt_q != fin) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			rd_v_s1 <= rd_en;
			rd_v_s2 <= rd_v_s1;
		end
	end

	// column of this step, edge replicated
	always_comb begin
		col_last = CW'(frame_width_q - FWW'(1));
		col_s    = SW'(em_col_q) + SW'(cnt_q) - SW'(kernel_half_q);
		if (col_s < 0) begin
			rd_col = '0;
		end else if (col_s > SW'(col_last)) begin
			rd_col = col_last;
		end else begin
			rd_col = CW'(col_s);
		end
		if (cnt_q >= CNTW'(kernel_half_q)) begin
			tap_idx = 2'(cnt_q - CNTW'(kernel_half_q));
		end else begin
			tap_idx = 2'(CNTW'(kernel_half_q) - cnt_q);
		end
		center = cnt_q == CNTW'(kernel_half_q);
	end

	always_ff @(posedge clk) begin
		center_s1 <= center;
		xtap_s1   <= x_taps_q[gblur_pkg::TAP_W*tap_idx +: gblur_pkg::TAP_W];
	end

	// row ring
	for (genvar g = 0; g < RING; g++) begin : g_ring
		gblur_ram #(
			.WIDTH(gblur_pkg::DATA_W),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk  (clk),
			.we   (in_acc && is_pix && (in_row_q[RB-1:0] == RB'(g))),
			.waddr(in_col_q),
			.wdata(s_axis_tdata),
			.re   (rd_en),
			.raddr(rd_col),
			.rdata(ring_pix[g])
		);
	end

	// cell chain
	assign row_last = RW'(frame_height_q - FHW'(1));
	assign chain[0] = '0;

	always_comb begin
		ctl.start       = start;
		ctl.rd_valid    = rd_v_s1;
		ctl.center      = center_s1;
		ctl.x_tap       = xtap_s1;
		ctl.prod_valid  = rd_v_s2;
		ctl.kernel_half = kernel_half_q;
		ctl.y_taps      = y_taps_q;
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		gblur_cell #(
			.RING_ROWS(RING),
			.ROW_W    (RW),
			.OFFSET   (g - MAX_HALF)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.em_row  (em_row_q),
			.row_last(row_last),
			.pix     (ring_pix),
			.psum_i  (chain[g]),
			.psum_o  (chain[g+1]),
			.raw     (raw[g])
		);
	end

	// result
	always_comb begin
		for (int ch = 0; ch < gblur_pkg::NCH; ch++) begin
			if (kernel_half_q == '0) begin
				res[ch] = raw[MAX_HALF][gblur_pkg::PIX_W*ch +: gblur_pkg::PIX_W];
			end else begin
				res[ch] = gblur_pkg::sat8(chain[NCELL][ch]);
			end
			if (ch != 0 && channel_count_q != gblur_pkg::COLOR_CHANNELS) begin
				res[ch] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= res;
			out_last_q <= fe_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- sv/gblur_chk.sv -----
// ----------------------------------------------------------------------------
// gblur_chk - port checker for the blur unit
// Tracks configuration writes and checks output words against them.
// ----------------------------------------------------------------------------
module gblur_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [gblur_pkg::DATA_W-1:0]     s_axis_tdata,
	input logic                             s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [gblur_pkg::DATA_W-1:0]     m_axis_tdata,
	input logic                             m_axis_tlast,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [gblur_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [gblur_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic color_q, w1_q, h1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= 1'b0;
			w1_q    <= 1'b0;
			h1_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gblur_pkg::REG_FRAME_WIDTH:
					w1_q <= cfg_data[gblur_pkg::SIZE_FIELD_W-1:0] <= 11'd1;
				gblur_pkg::REG_FRAME_HEIGHT:
					h1_q <= cfg_data[gblur_pkg::SIZE_FIELD_W-1:0] <= 11'd1;
				gblur_pkg::REG_CHANNEL_COUNT:
					color_q <= cfg_data[1:0] == gblur_pkg::COLOR_CHANNELS;
				default: ;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output word changed");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !color_q |-> m_axis_tdata[gblur_pkg::DATA_W-1:gblur_pkg::PIX_W] == '0)
		else $error("gray mode word carries color channels");

	a_single_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && w1_q && h1_q |-> m_axis_tlast)
		else $error("one-pixel frame word without tlast");

endmodule

bind separable_gaussian_blur_unit gblur_chk u_gblur_chk (.*);
